// ----- rtl/core/rflm_pkg.sv -----
package rflm_pkg;

    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;
    localparam logic [15:0] SEQ_HALF = 16'h8000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FOREIGN   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_CLEARED   = 2'd3
    } t_status;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_PAN_CHECK_EN = 2'd0,
        REG_PAN_MATCH    = 2'd1,
        REG_SRC_CHECK_EN = 2'd2,
        REG_SRC_MATCH    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              op;
        logic              frame_decoded;
        logic              header_valid;
        logic              dst_pan_present;
        logic [15:0]       dst_pan;
        logic              src_pan_present;
        logic [15:0]       src_pan;
        logic              src_short_mode;
        logic [15:0]       src_short;
        logic [15:0]       app_seq;
        logic signed [7:0] rssi_dbm;
        logic [7:0]        link_quality;
    } t_frame;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        ok_count;
        logic [31:0]        foreign_count;
        logic [31:0]        malformed_count;
        logic [31:0]        gap_count;
        logic [31:0]        dup_count;
        logic signed [7:0]  rssi_low;
        logic signed [7:0]  rssi_high;
        logic signed [31:0] rssi_total;
        logic [7:0]         lqi_low;
        logic [7:0]         lqi_high;
        logic [31:0]        lqi_total;
    } t_result;

    typedef struct packed {
        logic        pan_check_enable;
        logic [15:0] pan_match;
        logic        source_check_enable;
        logic [15:0] source_match;
    } t_cfg;

endpackage

// ----- rtl/core/rflm_if.sv -----
interface rflm_frame_if import rflm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frame data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rflm_result_if import rflm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/rflm_cfg.sv -----
module rflm_cfg import rflm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PAN_CHECK_EN: r_cfg.pan_check_enable    <= pwdata[0];
                REG_PAN_MATCH:    r_cfg.pan_match           <= pwdata[15:0];
                REG_SRC_CHECK_EN: r_cfg.source_check_enable <= pwdata[0];
                REG_SRC_MATCH:    r_cfg.source_match        <= pwdata[15:0];
                default:          r_cfg                     <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PAN_CHECK_EN: prdata = DataW'(r_cfg.pan_check_enable);
            REG_PAN_MATCH:    prdata = DataW'(r_cfg.pan_match);
            REG_SRC_CHECK_EN: prdata = DataW'(r_cfg.source_check_enable);
            REG_SRC_MATCH:    prdata = DataW'(r_cfg.source_match);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/rflm_filter.sv -----
module rflm_filter import rflm_pkg::*; (
    input  t_frame  i_frm,
    input  t_cfg    i_cfg,
    output t_status o_status
);

    logic [15:0] pan_sel;
    logic        pan_ok;
    logic        src_ok;
    logic        ours;
    logic        has_header;

    // destination PAN wins when both are present
    assign pan_sel = i_frm.dst_pan_present ? i_frm.dst_pan : i_frm.src_pan;
    assign pan_ok  = !i_cfg.pan_check_enable ||
                     ((i_frm.dst_pan_present || i_frm.src_pan_present) &&
                      (pan_sel == i_cfg.pan_match));
    assign src_ok  = !i_cfg.source_check_enable ||
                     (i_frm.src_short_mode && (i_frm.src_short == i_cfg.source_match));
    assign ours       = pan_ok && src_ok;
    assign has_header = i_frm.frame_decoded || i_frm.header_valid;

    always_comb begin
        if (i_frm.frame_decoded) begin
            o_status = ours ? ST_OK : ST_FOREIGN;
        end else if (has_header) begin
            o_status = ours ? ST_MALFORMED : ST_FOREIGN;
        end else begin
            o_status = ST_MALFORMED;
        end
    end

endmodule

// ----- rtl/core/rflm_stats.sv -----
module rflm_stats import rflm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    rflm_frame_if.sink          i_frm,
    rflm_result_if.source       o_res
);

    // input register
    logic   r_s1_vld;
    t_frame r_frm;

    // result register: status plus the statistics themselves
    logic    r_out_vld;
    t_status r_status;

    logic [31:0]        r_ok, r_foreign, r_malformed, r_gaps, r_dups;
    logic               r_seq_seen;
    logic [15:0]        r_prev_seq;
    logic signed [7:0]  r_rssi_min, r_rssi_max;
    logic [31:0]        r_rssi_sum;
    logic [7:0]         r_lqi_min, r_lqi_max;
    logic [31:0]        r_lqi_sum;

    logic [31:0]        n_ok, n_foreign, n_malformed, n_gaps, n_dups;
    logic               n_seq_seen;
    logic [15:0]        n_prev_seq;
    logic signed [7:0]  n_rssi_min, n_rssi_max;
    logic [31:0]        n_rssi_sum;
    logic [7:0]         n_lqi_min, n_lqi_max;
    logic [31:0]        n_lqi_sum;
    t_status            n_status;

    t_status     frm_status;
    logic        adv;
    logic        in_take;
    logic [15:0] delta;
    logic [15:0] gap_add;
    logic        is_dup;
    logic [31:0] ok_inc;

    rflm_filter u_filter (
        .i_frm    (r_frm),
        .i_cfg    (i_cfg),
        .o_status (frm_status)
    );

    assign adv         = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_frm.ready = !r_s1_vld || adv;
    assign in_take     = i_frm.valid && i_frm.ready;

    assign n_status = (r_frm.op == OP_CLEAR) ? ST_CLEARED : frm_status;
    assign delta    = r_frm.app_seq - r_prev_seq;
    assign gap_add  = delta - 16'd1;
    assign is_dup   = (delta == 16'd0) || (delta > SEQ_HALF);
    assign ok_inc   = r_ok + 32'd1;

    always_comb begin
        n_ok        = r_ok;
        n_foreign   = r_foreign;
        n_malformed = r_malformed;
        n_gaps      = r_gaps;
        n_dups      = r_dups;
        n_seq_seen  = r_seq_seen;
        n_prev_seq  = r_prev_seq;
        n_rssi_min  = r_rssi_min;
        n_rssi_max  = r_rssi_max;
        n_rssi_sum  = r_rssi_sum;
        n_lqi_min   = r_lqi_min;
        n_lqi_max   = r_lqi_max;
        n_lqi_sum   = r_lqi_sum;
        case (n_status)
            ST_CLEARED: begin
                n_ok        = '0;
                n_foreign   = '0;
                n_malformed = '0;
                n_gaps      = '0;
                n_dups      = '0;
                n_seq_seen  = 1'b0;
                n_prev_seq  = '0;
                n_rssi_min  = '0;
                n_rssi_max  = '0;
                n_rssi_sum  = '0;
                n_lqi_min   = '0;
                n_lqi_max   = '0;
                n_lqi_sum   = '0;
            end
            ST_FOREIGN:   n_foreign   = r_foreign + 32'd1;
            ST_MALFORMED: n_malformed = r_malformed + 32'd1;
            default: begin
                n_ok       = ok_inc;
                n_seq_seen = 1'b1;
                n_prev_seq = r_frm.app_seq;
                if (r_seq_seen) begin
                    if (is_dup) begin
                        n_dups = r_dups + 32'd1;
                    end else if (delta > 16'd1) begin
                        n_gaps = r_gaps + 32'(gap_add);
                    end
                end
                // reseed whenever the ok count lands on one, wrap included
                if (ok_inc == 32'd1) begin
                    n_rssi_min = r_frm.rssi_dbm;
                    n_rssi_max = r_frm.rssi_dbm;
                    n_lqi_min  = r_frm.link_quality;
                    n_lqi_max  = r_frm.link_quality;
                end else begin
                    if (r_frm.rssi_dbm < r_rssi_min) n_rssi_min = r_frm.rssi_dbm;
                    if (r_frm.rssi_dbm > r_rssi_max) n_rssi_max = r_frm.rssi_dbm;
                    if (r_frm.link_quality < r_lqi_min) n_lqi_min = r_frm.link_quality;
                    if (r_frm.link_quality > r_lqi_max) n_lqi_max = r_frm.link_quality;
                end
                n_rssi_sum = r_rssi_sum + {{24{r_frm.rssi_dbm[7]}}, r_frm.rssi_dbm};
                n_lqi_sum  = r_lqi_sum + 32'(r_frm.link_quality);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_frm <= i_frm.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= ST_OK;
            r_ok        <= '0;
            r_foreign   <= '0;
            r_malformed <= '0;
            r_gaps      <= '0;
            r_dups      <= '0;
            r_seq_seen  <= 1'b0;
            r_prev_seq  <= '0;
            r_rssi_min  <= '0;
            r_rssi_max  <= '0;
            r_rssi_sum  <= '0;
            r_lqi_min   <= '0;
            r_lqi_max   <= '0;
            r_lqi_sum   <= '0;
        end else if (adv) begin
            r_status    <= n_status;
            r_ok        <= n_ok;
            r_foreign   <= n_foreign;
            r_malformed <= n_malformed;
            r_gaps      <= n_gaps;
            r_dups      <= n_dups;
            r_seq_seen  <= n_seq_seen;
            r_prev_seq  <= n_prev_seq;
            r_rssi_min  <= n_rssi_min;
            r_rssi_max  <= n_rssi_max;
            r_rssi_sum  <= n_rssi_sum;
            r_lqi_min   <= n_lqi_min;
            r_lqi_max   <= n_lqi_max;
            r_lqi_sum   <= n_lqi_sum;
        end
    end

    assign o_res.valid                = r_out_vld;
    assign o_res.data.status          = r_status;
    assign o_res.data.ok_count        = r_ok;
    assign o_res.data.foreign_count   = r_foreign;
    assign o_res.data.malformed_count = r_malformed;
    assign o_res.data.gap_count       = r_gaps;
    assign o_res.data.dup_count       = r_dups;
    assign o_res.data.rssi_low        = r_rssi_min;
    assign o_res.data.rssi_high       = r_rssi_max;
    assign o_res.data.rssi_total      = r_rssi_sum;
    assign o_res.data.lqi_low         = r_lqi_min;
    assign o_res.data.lqi_high        = r_lqi_max;
    assign o_res.data.lqi_total       = r_lqi_sum;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_status == ST_CLEARED) |->
            (r_ok == '0) && (r_foreign == '0) && (r_malformed == '0) &&
            (r_gaps == '0) && (r_dups == '0) && (r_rssi_sum == '0) && (r_lqi_sum == '0))
        else $error("statistics not zero after clear");

    a_ok_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (n_status == ST_OK) |=> (r_ok == $past(r_ok) + 32'd1))
        else $error("ok frame did not bump ok count");

    a_reject_keeps_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && ((n_status == ST_FOREIGN) || (n_status == ST_MALFORMED)) |=>
            $stable(r_ok) && $stable(r_prev_seq) && $stable(r_lqi_sum) &&
            $stable(r_rssi_sum))
        else $error("rejected frame changed link statistics");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ok != '0) |-> (r_rssi_min <= r_rssi_max) && (r_lqi_min <= r_lqi_max))
        else $error("minimum above maximum");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_res.ready |=> r_out_vld && $stable(r_ok) && $stable(r_status))
        else $error("result changed while stalled");

endmodule

// ----- rtl/core/rx_frame_link_monitor_core.sv -----
// Receive frame link monitor.
// i_frm carries one frame summary (or a clear command) per transaction;
// o_res returns exactly one result per input transaction, in order: the
// frame's status and every link statistic as it stands after that frame.
// Configuration (PAN and short-source filter) is to be written through
// the APB port only while the block is idle; the block does not enforce
// this. pready is tied high, reads return the register value.
// An accepted transaction moves from the input register into the result
// register, which drives o_res (one input register, one result register).
// Throughput: one transaction per cycle unless o_res stalls; statistics
// are combinational compares and adds fed back into the result registers.
// Reset (i_rst_n low, synchronous) zeroes all statistics and the filter
// registers and empties both stages.
// When the receiver stalls, the result holds and one more transaction is
// taken into the input register; i_frm.ready drops after that until the
// result is taken.
module rx_frame_link_monitor_core import rflm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rflm_frame_if.sink       i_frm,
    rflm_result_if.source    o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    t_cfg cfg;

    rflm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rflm_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_frm   (i_frm),
        .o_res   (o_res)
    );

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rflm_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 125;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    rflm_frame_if  frm ();
    rflm_result_if res ();

    rx_frame_link_monitor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frm   (frm),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter settings as the block should hold them
    t_cfg        filter_cfg;

    // link statistics as the block should hold them
    logic [31:0]        ok_tally;
    logic [31:0]        foreign_tally;
    logic [31:0]        malformed_tally;
    logic [31:0]        gap_tally;
    logic [31:0]        dup_tally;
    logic               seq_known;
    logic [15:0]        seq_prev;
    logic signed [7:0]  rssi_lo;
    logic signed [7:0]  rssi_hi;
    logic signed [31:0] rssi_acc;
    logic [7:0]         lqi_min;
    logic [7:0]         lqi_max;
    logic [31:0]        lqi_sum;

    t_frame      frames_to_send[$];
    t_result     expected_stats[$];
    logic        frm_taken = 1'b0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    logic [15:0] seq_cursor = 16'h0000;

    function automatic void clear_link_stats();
        ok_tally        = '0;
        foreign_tally   = '0;
        malformed_tally = '0;
        gap_tally       = '0;
        dup_tally       = '0;
        seq_known       = 1'b0;
        seq_prev        = '0;
        rssi_lo         = '0;
        rssi_hi         = '0;
        rssi_acc        = '0;
        lqi_min         = '0;
        lqi_max         = '0;
        lqi_sum         = '0;
    endfunction

    // Classify one transaction, update the statistics, return what o_res should show.
    function automatic t_result tally_frame(input t_frame f);
        t_result     r;
        logic        accepted;
        logic [15:0] pan;
        logic [15:0] delta;
        logic [7:0]  rssi_raw;
        t_status     st;
        accepted = 1'b1;
        if (f.op == OP_CLEAR) begin
            clear_link_stats();
            st = ST_CLEARED;
        end else begin
            if (filter_cfg.pan_check_enable) begin
                if (f.dst_pan_present) begin
                    pan = f.dst_pan;
                end else if (f.src_pan_present) begin
                    pan = f.src_pan;
                end else begin
                    accepted = 1'b0;
                    pan = '0;
                end
                if (pan != filter_cfg.pan_match) accepted = 1'b0;
            end
            if (filter_cfg.source_check_enable &&
                (!f.src_short_mode || f.src_short != filter_cfg.source_match)) begin
                accepted = 1'b0;
            end
            // an undecoded frame is only foreign when its header says so
            if (f.frame_decoded) st = accepted ? ST_OK : ST_FOREIGN;
            else if (f.header_valid) st = accepted ? ST_MALFORMED : ST_FOREIGN;
            else st = ST_MALFORMED;

            if (st == ST_FOREIGN) begin
                foreign_tally = foreign_tally + 1;
            end else if (st == ST_MALFORMED) begin
                malformed_tally = malformed_tally + 1;
            end else begin
                rssi_raw = f.rssi_dbm;
                ok_tally = ok_tally + 1;
                if (!seq_known) begin
                    seq_known = 1'b1;
                end else begin
                    delta = f.app_seq - seq_prev;
                    if (delta == 16'h0000 || delta > SEQ_HALF) dup_tally = dup_tally + 1;
                    else if (delta > 16'h0001) gap_tally = gap_tally + {16'h0000, delta} - 1;
                end
                seq_prev = f.app_seq;
                if (ok_tally == 32'd1) begin
                    rssi_lo = rssi_raw;
                    rssi_hi = rssi_raw;
                    lqi_min = f.link_quality;
                    lqi_max = f.link_quality;
                end else begin
                    if ($signed(rssi_raw) < rssi_lo) rssi_lo = rssi_raw;
                    if ($signed(rssi_raw) > rssi_hi) rssi_hi = rssi_raw;
                    if (f.link_quality < lqi_min) lqi_min = f.link_quality;
                    if (f.link_quality > lqi_max) lqi_max = f.link_quality;
                end
                rssi_acc = rssi_acc + {{24{rssi_raw[7]}}, rssi_raw};
                lqi_sum  = lqi_sum + {24'h000000, f.link_quality};
            end
        end
        r.status          = st;
        r.ok_count        = ok_tally;
        r.foreign_count   = foreign_tally;
        r.malformed_count = malformed_tally;
        r.gap_count       = gap_tally;
        r.dup_count       = dup_tally;
        r.rssi_low        = rssi_lo;
        r.rssi_high       = rssi_hi;
        r.rssi_total      = rssi_acc;
        r.lqi_low         = lqi_min;
        r.lqi_high        = lqi_max;
        r.lqi_total       = lqi_sum;
        return r;
    endfunction

    function automatic t_frame build_frame(
        input logic        decoded,
        input logic        header,
        input logic        dst_present,
        input logic [15:0] dst,
        input logic        src_present,
        input logic [15:0] src,
        input logic        short_mode,
        input logic [15:0] short_addr,
        input logic [15:0] seq,
        input logic [7:0]  rssi,
        input logic [7:0]  lqi
    );
        t_frame f;
        f.op              = OP_FRAME;
        f.frame_decoded   = decoded;
        f.header_valid    = header;
        f.dst_pan_present = dst_present;
        f.dst_pan         = dst;
        f.src_pan_present = src_present;
        f.src_pan         = src;
        f.src_short_mode  = short_mode;
        f.src_short       = short_addr;
        f.app_seq         = seq;
        f.rssi_dbm        = rssi;
        f.link_quality    = lqi;
        return f;
    endfunction

    function automatic t_frame clear_frame();
        t_frame      f;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        f = noise[$bits(t_frame)-1:0];
        f.op = OP_CLEAR;
        return f;
    endfunction

    // Mostly frames aimed at the current filter with a plausible sequence,
    // the rest pure noise and the odd clear.
    function automatic t_frame random_frame();
        t_frame      f;
        logic [95:0] noise;
        int unsigned pick;
        noise = {$urandom, $urandom, $urandom};
        f = noise[$bits(t_frame)-1:0];
        pick = $urandom_range(99);
        if (pick < 3) begin
            f.op = OP_CLEAR;
            return f;
        end
        f.op = OP_FRAME;
        if (pick < 80) begin
            f.frame_decoded = ($urandom_range(9) != 0);
            f.header_valid  = 1'b1;
            if ($urandom_range(99) < 85) begin
                if (f.dst_pan_present) begin
                    f.dst_pan = filter_cfg.pan_match;
                end else begin
                    f.src_pan_present = 1'b1;
                    f.src_pan = filter_cfg.pan_match;
                end
            end
            if ($urandom_range(99) < 85) begin
                f.src_short_mode = 1'b1;
                f.src_short = filter_cfg.source_match;
            end
            case ($urandom_range(19))
                0: ;
                1: seq_cursor = seq_cursor + 16'($urandom_range(20, 2));
                2: seq_cursor = 16'($urandom);
                3: seq_cursor = seq_cursor - 16'($urandom_range(5, 1));
                default: seq_cursor = seq_cursor + 16'd1;
            endcase
            f.app_seq = seq_cursor;
        end
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PAN_CHECK_EN: filter_cfg.pan_check_enable    = value[0];
            REG_PAN_MATCH:    filter_cfg.pan_match           = value[15:0];
            REG_SRC_CHECK_EN: filter_cfg.source_check_enable = value[0];
            REG_SRC_MATCH:    filter_cfg.source_match        = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_filter(input logic pan_en, input logic [15:0] pan,
                              input logic src_en, input logic [15:0] src);
        apb_write(REG_PAN_CHECK_EN, {31'd0, pan_en});
        apb_write(REG_PAN_MATCH, {16'd0, pan});
        apb_write(REG_SRC_CHECK_EN, {31'd0, src_en});
        apb_write(REG_SRC_MATCH, {16'd0, src});
    endtask

    // settle after the negedge drive so queue and valid are stable
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (frames_to_send.size() != 0 || frm.valid || expected_stats.size() != 0);
    endtask

    // frame driver and receiver backpressure
    always @(negedge i_clk) begin
        if (frm.valid && !frm_taken) begin
            // hold the transaction until it is taken
        end else if (frames_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            frm.valid <= 1'b1;
            frm.data  <= frames_to_send.pop_front();
        end else begin
            frm.valid <= 1'b0;
        end
        res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result checker and predictor
    always @(posedge i_clk) begin
        t_result want;
        cycle_count++;
        frm_taken <= frm.valid && frm.ready;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = expected_stats.pop_front();
                check_field("status", 32'(res.data.status), 32'(want.status));
                check_field("ok_count", res.data.ok_count, want.ok_count);
                check_field("foreign_count", res.data.foreign_count, want.foreign_count);
                check_field("malformed_count", res.data.malformed_count,
                            want.malformed_count);
                check_field("gap_count", res.data.gap_count, want.gap_count);
                check_field("dup_count", res.data.dup_count, want.dup_count);
                check_field("rssi_low", 32'(res.data.rssi_low), 32'(want.rssi_low));
                check_field("rssi_high", 32'(res.data.rssi_high), 32'(want.rssi_high));
                check_field("rssi_total", res.data.rssi_total, want.rssi_total);
                check_field("lqi_low", 32'(res.data.lqi_low), 32'(want.lqi_low));
                check_field("lqi_high", 32'(res.data.lqi_high), 32'(want.lqi_high));
                check_field("lqi_total", res.data.lqi_total, want.lqi_total);
            end
        end
        if (i_rst_n && frm.valid && frm.ready) expected_stats.push_back(tally_frame(frm.data));
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        frm.valid = 1'b0;
        frm.data  = '0;
        res.ready = 1'b0;
        filter_cfg = '0;
        clear_link_stats();
        tx_idle_pct = 16;
        rx_idle_pct = 88;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // filters off after reset: sequence tracking, seeding, wrap, clear
        frames_to_send.push_back(build_frame(1, 1, 1, 16'h0, 0, 16'h0, 1, 16'h0,
                                             16'h0000, 8'h80, 8'h00));
        frames_to_send.push_back(build_frame(1, 0, 0, 16'h0, 0, 16'h0, 0, 16'h0,
                                             16'h0001, 8'h7F, 8'hFF));
        frames_to_send.push_back(build_frame(1, 1, 1, 16'h1, 1, 16'h2, 1, 16'h3,
                                             16'h0001, 8'hFF, 8'h01));
        // delta of exactly half the space is a gap, one past it a duplicate
        frames_to_send.push_back(build_frame(1, 1, 0, 16'h0, 1, 16'hFFFF, 0, 16'hFFFF,
                                             16'h8001, 8'h01, 8'hFE));
        frames_to_send.push_back(build_frame(1, 1, 1, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF,
                                             16'h0002, 8'hC0, 8'h40));
        frames_to_send.push_back(build_frame(1, 1, 1, 16'h5, 0, 16'h0, 1, 16'h9,
                                             16'hFFFF, 8'h20, 8'h10));
        frames_to_send.push_back(build_frame(1, 1, 1, 16'h5, 0, 16'h0, 1, 16'h9,
                                             16'h0000, 8'h80, 8'hFF));
        frames_to_send.push_back(build_frame(0, 1, 1, 16'h0, 0, 16'h0, 1, 16'h0,
                                             16'h0100, 8'h00, 8'h00));
        frames_to_send.push_back(build_frame(0, 0, 0, 16'h0, 0, 16'h0, 0, 16'h0,
                                             16'h0200, 8'h7F, 8'hFF));
        frames_to_send.push_back(clear_frame());
        frames_to_send.push_back(build_frame(1, 1, 1, 16'h0, 1, 16'h0, 1, 16'h0,
                                             16'h1234, 8'h00, 8'h80));
        wait_idle();

        // both filters at their extremes
        set_filter(1'b1, 16'hFFFF, 1'b1, 16'h0000);
        frames_to_send.push_back(build_frame(1, 1, 1, 16'hFFFF, 0, 16'h0, 1, 16'h0000,
                                             16'h1235, 8'h10, 8'h20));
        frames_to_send.push_back(build_frame(1, 0, 0, 16'h0, 1, 16'hFFFF, 1, 16'h0000,
                                             16'h1236, 8'hF0, 8'h30));
        frames_to_send.push_back(build_frame(1, 1, 0, 16'hFFFF, 0, 16'hFFFF, 1, 16'h0000,
                                             16'h1237, 8'h00, 8'h00));
        // destination PAN wins over a matching source PAN
        frames_to_send.push_back(build_frame(1, 1, 1, 16'hFFFE, 1, 16'hFFFF, 1, 16'h0000,
                                             16'h1238, 8'h00, 8'h00));
        frames_to_send.push_back(build_frame(1, 1, 1, 16'hFFFF, 0, 16'h0, 0, 16'h0000,
                                             16'h1239, 8'h00, 8'h00));
        frames_to_send.push_back(build_frame(1, 1, 1, 16'hFFFF, 0, 16'h0, 1, 16'h0001,
                                             16'h123A, 8'h00, 8'h00));
        frames_to_send.push_back(build_frame(0, 1, 1, 16'h0000, 0, 16'h0, 1, 16'h0000,
                                             16'h123B, 8'h00, 8'h00));
        frames_to_send.push_back(build_frame(0, 1, 1, 16'hFFFF, 0, 16'h0, 1, 16'h0000,
                                             16'h123C, 8'h00, 8'h00));
        frames_to_send.push_back(build_frame(0, 0, 0, 16'h0, 0, 16'h0, 0, 16'h0,
                                             16'h123D, 8'h00, 8'h00));
        frames_to_send.push_back(clear_frame());

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if (p < 2) begin
                tx_idle_pct = 16;
                rx_idle_pct = 88;
            end else if (p < 4) begin
                tx_idle_pct = 88;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: set_filter(1'b1, 16'($urandom), 1'b0, 16'($urandom));
                1: set_filter(1'b0, 16'h0000, 1'b0, 16'h0000);
                2: set_filter(1'b0, 16'($urandom), 1'b1, 16'($urandom));
                3: set_filter(1'b1, 16'($urandom), 1'b1, 16'($urandom));
                4: set_filter(1'b1, 16'h0000, 1'b1, 16'hFFFF);
                default: set_filter(1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off mid-phase until every result is back
                if (p == 2 && n == PHASE_ITEMS / 2) wait_idle();
                frames_to_send.push_back(random_frame());
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
